>>> hdl/pattern_occurrence_finder_core_assert.svh
// Assertion macros for the pattern occurrence finder.
// Needs a clock and an active-high synchronous reset at the point of use.
`ifndef PATTERN_OCCURRENCE_FINDER_CORE_ASSERT_SVH
`define PATTERN_OCCURRENCE_FINDER_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define POF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define POF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/pof_pkg.sv
// Package for the pattern occurrence finder: field widths and mode codes.
// No dependencies.
package pof_pkg;

  localparam int BYTE_W    = 8;
  localparam int INDEX_W   = 6;
  localparam int CFG_LEN_W = 7;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_LOAD    = 2'd0;
  localparam mode_t MODE_SEARCH  = 2'd1;
  localparam mode_t MODE_RESTART = 2'd2;

endpackage

>>> hdl/pattern_occurrence_finder_core.sv
// Pattern occurrence finder: naive substring search over a byte stream.
// Depends on pof_pkg and pattern_occurrence_finder_core_assert.svh.
//
//   channel | handshake                 | payload
//   --------+---------------------------+----------------------------------
//   in      | in_valid / in_ready       | mode, data_byte, pattern_index
//   out     | out_valid / out_ready     | match_offset
//   cfg     | cfg_wr_en (no wait)       | cfg_wr_data -> pattern_length
//
// One transaction per cycle sustained while out is not stalled. An input
// transaction lands in an input register; a single pass (pattern alignment
// shifter, one byte compare per window lane, AND tree) then writes the result
// register once it is free or being drained, so a match reaches out through the input and result registers.
// rst (synchronous) clears control state, counters and the fill count; pattern
// length returns to 1. A stall on out holds a full input register and drops in_ready.
`include "pattern_occurrence_finder_core_assert.svh"

module pattern_occurrence_finder_core #(
  parameter int MAX_LEN     = 64,
  parameter int OFFSET_BITS = 40
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_wr_en,
  input  logic [pof_pkg::CFG_LEN_W-1:0]   cfg_wr_data,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  pof_pkg::mode_t                  mode,
  input  logic [pof_pkg::BYTE_W-1:0]      data_byte,
  input  logic [pof_pkg::INDEX_W-1:0]     pattern_index,
  // output channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [OFFSET_BITS-1:0]          match_offset
);

  import pof_pkg::*;

  // Width that holds 0..MAX_LEN (fill count, effective length).
  localparam int LEN_W = $clog2(MAX_LEN + 1);
  // Common width for comparing the 7-bit register against MAX_LEN.
  localparam int CMP_W = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;
  // Common width for comparing a load index against entry numbers.
  localparam int IDX_X_W = (LEN_W > INDEX_W) ? LEN_W : INDEX_W;
  localparam int VEC_W = MAX_LEN * BYTE_W;

  // ---------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------
  logic [CFG_LEN_W-1:0] pattern_length;

  logic                 s1_valid;
  mode_t                s1_mode;
  logic [BYTE_W-1:0]    s1_data;
  logic [INDEX_W-1:0]   s1_index;

  logic [BYTE_W-1:0]    pattern_store [MAX_LEN];
  logic [BYTE_W-1:0]    window [MAX_LEN];
  logic [OFFSET_BITS-1:0] bytes_seen;
  logic [LEN_W-1:0]     window_fill;

  // ---------------------------------------------------------------------
  // Handshake: stage 1 retires when the result register is free or
  // being drained this cycle. Non-matching items retire without output.
  // ---------------------------------------------------------------------
  logic s1_fire;
  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  // ---------------------------------------------------------------------
  // Effective length: zero reads as 1, above MAX_LEN clamps.
  // ---------------------------------------------------------------------
  logic [CMP_W-1:0] len_x;
  logic [LEN_W-1:0] len_eff;

  always_comb begin
    len_x = CMP_W'(pattern_length);
    if (len_x == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_x > CMP_W'(MAX_LEN)) begin
      len_eff = LEN_W'(MAX_LEN);
    end else begin
      len_eff = len_x[LEN_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Pattern alignment: lane k must compare against pattern[len-1-k].
  // Reverse the pattern into a flat vector and shift it down by
  // MAX_LEN-len lanes (log shifter, not a per-lane wide mux).
  // ---------------------------------------------------------------------
  logic [VEC_W-1:0] rev_vec;
  logic [VEC_W-1:0] align_vec;
  logic [LEN_W-1:0] lane_shift;

  always_comb begin
    for (int j = 0; j < MAX_LEN; j++) begin
      rev_vec[j*BYTE_W +: BYTE_W] = pattern_store[MAX_LEN-1-j];
    end
    lane_shift = LEN_W'(MAX_LEN) - len_eff;
    align_vec  = rev_vec >> {lane_shift, 3'b000};
  end

  // ---------------------------------------------------------------------
  // Search datapath for the item in stage 1.
  // ---------------------------------------------------------------------
  logic [BYTE_W-1:0]      window_next [MAX_LEN];
  logic [LEN_W-1:0]       fill_inc;
  logic [MAX_LEN-1:0]     lane_ok;
  logic                   hit;
  logic [OFFSET_BITS-1:0] offset_calc;

  always_comb begin
    window_next[0] = s1_data;
    for (int k = 1; k < MAX_LEN; k++) begin
      window_next[k] = window[k-1];
    end

    fill_inc = (window_fill < LEN_W'(MAX_LEN)) ? window_fill + LEN_W'(1) : window_fill;

    // lanes past the pattern length always agree
    for (int k = 0; k < MAX_LEN; k++) begin
      lane_ok[k] = (LEN_W'(k) >= len_eff) ||
                   (window_next[k] == align_vec[k*BYTE_W +: BYTE_W]);
    end

    hit = (s1_mode == MODE_SEARCH) && (fill_inc >= len_eff) && (&lane_ok);

    // start of the occurrence, wrapping with the counter
    offset_calc = bytes_seen - (OFFSET_BITS'(len_eff) - OFFSET_BITS'(1));
  end

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= CFG_LEN_W'(1);
    end else if (cfg_wr_en) begin
      pattern_length <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_mode  <= mode;
      s1_data  <= data_byte;
      s1_index <= pattern_index;
    end
  end

  // ---------------------------------------------------------------------
  // Pattern store: one write port, entries read in place by the shifter.
  // Loads at or above MAX_LEN match no entry and are dropped.
  // ---------------------------------------------------------------------
  logic [IDX_X_W-1:0] load_idx;
  assign load_idx = IDX_X_W'(s1_index);

  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_LEN; j++) begin
      if (s1_fire && (s1_mode == MODE_LOAD) && (load_idx == IDX_X_W'(j))) begin
        pattern_store[j] <= s1_data;
      end
    end
  end

  // Window shift line: payload only, fill count guards stale lanes.
  always_ff @(posedge clk) begin
    if (s1_fire && (s1_mode == MODE_SEARCH)) begin
      for (int k = 0; k < MAX_LEN; k++) begin
        window[k] <= window_next[k];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stream counters; mode three falls through and changes nothing.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen  <= '0;
      window_fill <= '0;
    end else if (s1_fire) begin
      case (s1_mode)
        MODE_SEARCH: begin
          bytes_seen  <= bytes_seen + OFFSET_BITS'(1);
          window_fill <= fill_inc;
        end
        MODE_RESTART: begin
          bytes_seen  <= '0;
          window_fill <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= hit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && hit) begin
      match_offset <= offset_calc;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `POF_ASSERT_NEXT(a_no_hit_no_result, clk, rst, s1_fire && !hit, !out_valid,
    "result produced by an item that did not match")
  `POF_ASSERT_NOW(a_fill_bounded, clk, rst, 1'b1, window_fill <= LEN_W'(MAX_LEN),
    "window fill count above MAX_LEN")
  `POF_ASSERT_NEXT(a_restart_clears, clk, rst, s1_fire && (s1_mode == MODE_RESTART),
    (bytes_seen == '0) && (window_fill == '0), "restart did not clear counters")
  `POF_ASSERT_NEXT(a_search_counts, clk, rst, s1_fire && (s1_mode == MODE_SEARCH),
    bytes_seen == OFFSET_BITS'($past(bytes_seen) + OFFSET_BITS'(1)),
    "offset counter did not advance on search byte")

endmodule
